// ----- hdl/tbe_pkg.sv -----
// ----------------------------------------------------------------------------
// tbe_pkg
// Types and constants of the three-band equaliser: register map, field widths,
// reset values, sequencer states and the control word of the datapath.
// ----------------------------------------------------------------------------
package tbe_pkg;

  // Default widths
  localparam int unsigned SAMPLE_WIDTH_DEF = 24;
  localparam int unsigned POLE_WIDTH_DEF   = 32;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned KNOB_W     = 18;
  localparam int unsigned COEF_W     = 24;

  // Q2.22 coefficients, Q2.16 gains
  localparam int unsigned COEF_FRAC = 22;
  localparam int unsigned GAIN_FRAC = 16;

  localparam logic [COEF_W-1:0] COEF_MAX = COEF_W'(8388608);
  localparam logic [KNOB_W-1:0] GAIN_MAX = KNOB_W'(131072);

  // Register reset values
  localparam logic [KNOB_W-1:0] KNOB_RST     = KNOB_W'(65536);
  localparam logic [COEF_W-1:0] LOW_COEF_RST  = COEF_W'(525530);
  localparam logic [COEF_W-1:0] HIGH_COEF_RST = COEF_W'(2925180);

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_KNOB  = 3'd0,
    REG_MID_KNOB  = 3'd1,
    REG_HIGH_KNOB = 3'd2,
    REG_LOW_COEF  = 3'd3,
    REG_HIGH_COEF = 3'd4
  } tbe_reg_e;

  // Band order of the output phase
  localparam logic [1:0] BAND_LOW  = 2'd0;
  localparam logic [1:0] BAND_MID  = 2'd1;
  localparam logic [1:0] BAND_HIGH = 2'd2;

  // Last step of the pole line (four low stages, then four high stages)
  localparam logic [2:0] STAGE_LAST     = 3'd7;
  localparam logic [2:0] STAGE_LOW_LAST = 3'd3;

  typedef enum logic [3:0] {
    ST_IDLE,  // wait for an item
    ST_DIFF,  // operand: stage input minus pole
    ST_MUL,   // product: difference times coefficient
    ST_UPD,   // pole update with saturation, rotate pole line
    ST_DIV,   // operand: offset control voltage and reciprocal of five
    ST_DMUL,  // product: quotient estimate
    ST_QUO,   // quotient correction
    ST_BAND,  // operand: band value and clamped gain
    ST_GMUL,  // product: band times gain
    ST_ACC,   // accumulate weighted band
    ST_OUT    // saturate and hand to output register
  } tbe_state_e;

  typedef struct packed {
    logic ld_diff;
    logic ld_prod;
    logic ld_upd;
    logic ld_div;
    logic ld_quo;
    logic ld_band;
    logic ld_acc;
    logic ld_out;
  } tbe_ctrl_t;

endpackage

// ----- hdl/three_band_equalizer.sv -----
// ----------------------------------------------------------------------------
// three_band_equalizer - one channel, fourth-order one-pole band split
// A new item is taken only while idle, after the last result has gone into
// the output register; the single shared multiplier is used fourteen times
// per item, once per filter stage and twice per band.
// Reset: poles, history and sequencer clear; registers take their defaults.
// ----------------------------------------------------------------------------
module three_band_equalizer #(
  parameter int unsigned SAMPLE_WIDTH = tbe_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned POLE_WIDTH   = tbe_pkg::POLE_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [tbe_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tbe_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // input items
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]   sample_in_i,
  input  logic signed [SAMPLE_WIDTH-1:0]   low_cv_i,
  input  logic signed [SAMPLE_WIDTH-1:0]   mid_cv_i,
  input  logic signed [SAMPLE_WIDTH-1:0]   high_cv_i,
  // result items
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]   sample_out_o
);

  import tbe_pkg::*;

  localparam int unsigned SW = SAMPLE_WIDTH;
  localparam int unsigned PW = POLE_WIDTH;

  // Sample to pole scale: widen and shift up, or floor-shift down.
  localparam int unsigned XW   = (PW >= SW) ? PW : SW;
  localparam int unsigned UP_S = (PW >= SW) ? PW - SW : 0;
  localparam int unsigned DN_S = (PW >= SW) ? 0 : SW - PW;

  // floor(cv / 80) = floor(floor(cv / 16) / 5). The quotient by five runs on
  // the shared multiplier: the shifted voltage is made positive by adding
  // five times 2^(SW-5), multiplied by floor(2^UW / 5), and corrected once.
  localparam int unsigned UW = SW - 2;       // offset voltage, always positive
  localparam int unsigned QW = SW - 4;       // quotient by five of it
  localparam logic signed [SW-1:0] DIV_OFF = SW'(5 * (1 << (SW - 5)));
  localparam logic [QW-1:0]        QUO_OFF = QW'(1 << (SW - 5));

  // Shared multiplier: signed operand a, unsigned operand b.
  localparam int unsigned AW  = (PW + 1 > SW - 1) ? PW + 1 : SW - 1;
  localparam int unsigned BW  = (SW - 4 > COEF_W) ? SW - 4 : COEF_W;
  localparam int unsigned PRW = AW + BW + 1;
  localparam int unsigned ACW = PRW + 2;
  localparam int unsigned GW  = SW + 4;
  localparam int unsigned OSH = GAIN_FRAC + PW - SW;

  localparam logic [BW-1:0] DIV_RECIP = BW'((64'd1 << UW) / 64'd5);

  localparam logic signed [PRW-1:0] PMAX = {{(PRW - PW + 1){1'b0}}, {(PW - 1){1'b1}}};
  localparam logic signed [PRW-1:0] PMIN = ~PMAX;
  localparam logic signed [ACW-1:0] SMAX = {{(ACW - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
  localparam logic signed [ACW-1:0] SMIN = ~SMAX;

  function automatic logic signed [PW-1:0] to_pole(input logic signed [SW-1:0] x);
    logic signed [XW-1:0] xw;
    xw = XW'(x);
    return PW'((xw <<< UP_S) >>> DN_S);
  endfunction

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  tbe_state_e state_q, state_d;
  tbe_ctrl_t  ctrl;

  logic [KNOB_W-1:0] knob_q [3];
  logic [COEF_W-1:0] low_coef_q, high_coef_q;

  // Pole line: entries 0..3 the low chain, 4..7 the high split chain. Each
  // update works on entry 0 and rotates the line, so after eight updates
  // every pole is back in place.
  logic signed [PW-1:0] pl_q [8];
  logic signed [SW-1:0] hist_q [3];

  logic signed [SW-1:0] sample_q;
  logic signed [SW-1:0] cv_q [3];
  logic signed [PW-1:0] src_q;       // input of the stage in progress
  logic [2:0]           step_q;      // stage, then band, in progress

  logic signed [AW-1:0]  a_q;
  logic [BW-1:0]         b_q;
  logic signed [PRW-1:0] prod_q;
  logic [QW-1:0]         quo_q;
  logic signed [ACW-1:0] acc_q;

  logic                 out_valid_q;
  logic signed [SW-1:0] out_q;

  logic in_fire;
  logic out_free;

  assign in_ready_o   = (state_q == ST_IDLE);
  assign in_fire      = in_valid_i && in_ready_o;
  assign out_free     = !out_valid_q || out_ready_i;
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

  // --------------------------------------------------------------------------
  // Configuration registers; writes beyond the map are dropped.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      knob_q[0]   <= KNOB_RST;
      knob_q[1]   <= KNOB_RST;
      knob_q[2]   <= KNOB_RST;
      low_coef_q  <= LOW_COEF_RST;
      high_coef_q <= HIGH_COEF_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LOW_KNOB:  knob_q[0]   <= cfg_data_i[KNOB_W-1:0];
        REG_MID_KNOB:  knob_q[1]   <= cfg_data_i[KNOB_W-1:0];
        REG_HIGH_KNOB: knob_q[2]   <= cfg_data_i[KNOB_W-1:0];
        REG_LOW_COEF:  low_coef_q  <= cfg_data_i[COEF_W-1:0];
        REG_HIGH_COEF: high_coef_q <= cfg_data_i[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_DIFF;
      ST_DIFF: state_d = ST_MUL;
      ST_MUL:  state_d = ST_UPD;
      ST_UPD:  state_d = (step_q == STAGE_LAST) ? ST_DIV : ST_DIFF;
      ST_DIV:  state_d = ST_DMUL;
      ST_DMUL: state_d = ST_QUO;
      ST_QUO:  state_d = ST_BAND;
      ST_BAND: state_d = ST_GMUL;
      ST_GMUL: state_d = ST_ACC;
      ST_ACC:  state_d = (step_q[1:0] == BAND_HIGH) ? ST_OUT : ST_DIV;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer: control word
  always_comb begin
    ctrl = '0;
    case (state_q)
      ST_DIFF: ctrl.ld_diff = 1'b1;
      ST_MUL:  ctrl.ld_prod = 1'b1;
      ST_UPD:  ctrl.ld_upd  = 1'b1;
      ST_DIV:  ctrl.ld_div  = 1'b1;
      ST_DMUL: ctrl.ld_prod = 1'b1;
      ST_QUO:  ctrl.ld_quo  = 1'b1;
      ST_BAND: ctrl.ld_band = 1'b1;
      ST_GMUL: ctrl.ld_prod = 1'b1;
      ST_ACC:  ctrl.ld_acc  = 1'b1;
      ST_OUT:  ctrl.ld_out  = out_free;
      default: ctrl = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  logic [1:0]            band;
  logic [COEF_W-1:0]     coef_raw, coef_sat;
  logic signed [PRW-1:0] prod_d;
  logic signed [PRW-1:0] upd_sum;
  logic signed [PW-1:0]  pole_new;
  logic signed [SW-1:0]  cv_sel, cv_shift;
  logic [UW-1:0]         div_u;
  logic [QW-1:0]         quo_est;
  logic [UW:0]           est_x5;
  logic [QW-1:0]         quo_d;
  logic [UW:0]           quo_x5;
  logic [GW-1:0]         gain_sum;
  logic [KNOB_W-1:0]     gain;
  logic signed [PW-1:0]  d_pole;
  logic signed [AW-1:0]  band_val;
  logic signed [ACW-1:0] out_shift;
  logic signed [SW-1:0]  out_sat;

  assign band = step_q[1:0];

  // The shared multiplier: AW-bit signed by BW-bit unsigned.
  assign prod_d = PRW'(a_q) * PRW'($signed({1'b0, b_q}));

  // Coefficient of the chain in progress, capped at 2.0.
  assign coef_raw = step_q[2] ? high_coef_q : low_coef_q;
  assign coef_sat = (coef_raw > COEF_MAX) ? COEF_MAX : coef_raw;

  // Pole update: p + floor(c * (src - p) / 2^22), saturated.
  assign upd_sum = PRW'(pl_q[0]) + (prod_q >>> COEF_FRAC);
  always_comb begin
    if (upd_sum > PMAX) begin
      pole_new = PW'(PMAX);
    end else if (upd_sum < PMIN) begin
      pole_new = PW'(PMIN);
    end else begin
      pole_new = PW'(upd_sum);
    end
  end

  // Control voltage of the band, shifted and made positive.
  assign cv_sel   = cv_q[band];
  assign cv_shift = (cv_sel >>> 4) + DIV_OFF;
  assign div_u    = cv_shift[UW-1:0];

  // Quotient estimate is low by at most one: bump it where u >= 5q + 5.
  assign quo_est = prod_q[UW +: QW];
  assign est_x5  = (UW + 1)'({quo_est, 2'b00}) + (UW + 1)'(quo_est);
  assign quo_d   = ({1'b0, a_q[UW-1:0]} >= est_x5 + (UW + 1)'(5)) ? quo_est + QW'(1)
                                                                  : quo_est;
  assign quo_x5  = (UW + 1)'({quo_q, 2'b00}) + (UW + 1)'(quo_q);

  // Gain: knob + floor(cv / 80), clamped to 0..2.
  assign gain_sum = GW'(knob_q[band]) + GW'(quo_q) - GW'(QUO_OFF);
  always_comb begin
    if (gain_sum[GW-1]) begin
      gain = '0;
    end else if (gain_sum > GW'(GAIN_MAX)) begin
      gain = GAIN_MAX;
    end else begin
      gain = gain_sum[KNOB_W-1:0];
    end
  end

  // Band values: low is the last low pole, high the delayed input minus the
  // last split pole, mid whatever is left of the delayed input.
  assign d_pole = to_pole(hist_q[2]);
  always_comb begin
    case (band)
      BAND_LOW:  band_val = AW'(pl_q[3]);
      BAND_MID:  band_val = AW'(pl_q[7]) - AW'(pl_q[3]);
      BAND_HIGH: band_val = AW'(d_pole) - AW'(pl_q[7]);
      default:   band_val = '0;
    endcase
  end

  // Output: drop the gain and pole fraction, saturate to the sample range.
  assign out_shift = acc_q >>> OSH;
  always_comb begin
    if (out_shift > SMAX) begin
      out_sat = SW'(SMAX);
    end else if (out_shift < SMIN) begin
      out_sat = SW'(SMIN);
    end else begin
      out_sat = SW'(out_shift);
    end
  end

  // Payload registers of the item in progress
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sample_q <= sample_in_i;
      cv_q[0]  <= low_cv_i;
      cv_q[1]  <= mid_cv_i;
      cv_q[2]  <= high_cv_i;
      src_q    <= to_pole(sample_in_i);
      acc_q    <= '0;
    end
    if (ctrl.ld_diff) begin
      a_q <= AW'(src_q) - AW'(pl_q[0]);
      b_q <= BW'(coef_sat);
    end
    if (ctrl.ld_prod) begin
      prod_q <= prod_d;
    end
    if (ctrl.ld_upd) begin
      // the second chain starts again from the input sample
      src_q <= (step_q == STAGE_LOW_LAST) ? to_pole(sample_q) : pole_new;
    end
    if (ctrl.ld_div) begin
      a_q <= AW'({1'b0, div_u});
      b_q <= DIV_RECIP;
    end
    if (ctrl.ld_quo) begin
      quo_q <= quo_d;
    end
    if (ctrl.ld_band) begin
      a_q <= band_val;
      b_q <= BW'(gain);
    end
    if (ctrl.ld_acc) begin
      acc_q <= acc_q + ACW'(prod_q);
    end
    if (ctrl.ld_out) begin
      out_q <= out_sat;
    end
  end

  // Filter state, history and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        pl_q[i] <= '0;
      end
      hist_q[0] <= '0;
      hist_q[1] <= '0;
      hist_q[2] <= '0;
      step_q    <= '0;
    end else begin
      if (in_fire) begin
        step_q <= '0;
      end else if (ctrl.ld_upd || ctrl.ld_acc) begin
        step_q <= step_q + 3'd1;
      end
      if (ctrl.ld_upd) begin
        for (int i = 0; i < 7; i++) begin
          pl_q[i] <= pl_q[i+1];
        end
        pl_q[7] <= pole_new;
      end
      if (ctrl.ld_out) begin
        hist_q[2] <= hist_q[1];
        hist_q[1] <= hist_q[0];
        hist_q[0] <= sample_q;
      end
    end
  end

  // Output register: hold the result until it is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.ld_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("block still ready after taking an item");

  a_coef_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> (b_q <= BW'(COEF_MAX)))
    else $error("coefficient operand above 2.0");

  a_quotient : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BAND) |-> (quo_x5 <= {1'b0, a_q[UW-1:0]}) &&
                             ({1'b0, a_q[UW-1:0]} < quo_x5 + (UW + 1)'(5)))
    else $error("quotient by five off after correction");

  a_gain_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GMUL) |-> (b_q <= BW'(GAIN_MAX)))
    else $error("band gain above 2.0");

  a_out_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_OUT))
    else $error("result loaded outside the output step");

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb - self-checking bench of the three-band equaliser
// Drives audio items with random idling on both handshakes, keeps its own
// fixed-point model of the two filter cascades, the band split and the gain
// stage, and compares every output item with the predicted sample.
// ----------------------------------------------------------------------------
module tb;
  import tbe_pkg::*;

  localparam int SW = SAMPLE_WIDTH_DEF;
  localparam int PW = POLE_WIDTH_DEF;

  // Register indexes past the map; writes to them must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = 3'd5;

  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW - 1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW - 1){1'b0}}};
  // All data bits set: a knob above 2.0 and a coefficient above 2.0
  localparam logic [CFG_DATA_W-1:0] DATA_ALL_ONES = {CFG_DATA_W{1'b1}};

  localparam int CV_PER_GAIN_LSB = 80;     // cv / 80 is cv volts / 10 in Q16
  localparam int COEF_SPLIT      = 11;     // coefficient split into two parts
  localparam int GAIN_SPLIT      = 8;      // gain split into two parts
  localparam int OUT_SHIFT       = GAIN_FRAC - GAIN_SPLIT + PW - SW;

  localparam int RANDOM_PHASES   = 7;
  localparam int PHASE_ITEMS     = 265;
  localparam int WALK_STEP       = 300000;
  localparam int CV_SPAN         = 6000000;
  localparam int SETTLE_CYCLES   = 60;     // longer than the pass of one item through the block
  localparam int CYCLE_LIMIT     = 1000000;

  typedef struct packed {
    logic signed [SW-1:0] sample;
    logic signed [SW-1:0] low_cv;
    logic signed [SW-1:0] mid_cv;
    logic signed [SW-1:0] high_cv;
  } eq_item_t;

  // Bench signals; the ones the bench drives are known from time zero
  logic                    clk_i      = 1'b0;
  logic                    rst_ni     = 1'b0;
  logic                    cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx    = '0;
  logic [CFG_DATA_W-1:0]   cfg_data   = '0;
  logic                    in_valid   = 1'b0;
  logic                    in_ready_o;
  logic signed [SW-1:0]    sample_in  = '0;
  logic signed [SW-1:0]    low_cv     = '0;
  logic signed [SW-1:0]    mid_cv     = '0;
  logic signed [SW-1:0]    high_cv    = '0;
  logic                    out_valid_o;
  logic                    out_ready  = 1'b0;
  logic signed [SW-1:0]    sample_out_o;

  bit                      calm        = 1'b0;  // no idling on either side
  int                      error_count = 0;
  int unsigned             cycle_count = 0;
  int                      burst_left  = 0;
  logic signed [SW-1:0]    walk_level  = '0;

  // Equaliser state as the bench sees it
  longint                  lowpass_state[4];
  longint                  split_state[4];
  longint                  past_samples[3];
  logic [KNOB_W-1:0]       knob_low, knob_mid, knob_high;
  logic [COEF_W-1:0]       coef_low, coef_high;

  logic signed [SW-1:0]    expected_samples[$];

  three_band_equalizer DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .sample_in_i  (sample_in),
    .low_cv_i     (low_cv),
    .mid_cv_i     (mid_cv),
    .high_cv_i    (high_cv),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .sample_out_o (sample_out_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Equaliser model
  // --------------------------------------------------------------------------

  // Saturate to a signed range of the given width
  function automatic longint clip(longint v, int w);
    longint top;
    top = (longint'(1) <<< (w - 1)) - 1;
    if (v > top) return top;
    if (v < -top - 1) return -top - 1;
    return v;
  endfunction

  // floor(c * d / 2^22), with c split so that no product overflows
  function automatic longint scale_by_coef(longint c, longint d);
    longint c_hi, c_lo;
    c_hi = c >>> COEF_SPLIT;
    c_lo = c & ((longint'(1) <<< COEF_SPLIT) - 1);
    return (d * c_hi + ((d * c_lo) >>> COEF_SPLIT)) >>> COEF_SPLIT;
  endfunction

  // Knob plus floored cv / 80, clamped to 0..2 in Q2.16
  function automatic longint knob_plus_cv(logic [KNOB_W-1:0] knob,
                                          logic signed [SW-1:0] cv);
    longint v, q, g;
    v = longint'(cv);
    q = (v >= 0) ? v / CV_PER_GAIN_LSB : -((-v - 1) / CV_PER_GAIN_LSB) - 1;
    g = longint'(knob) + q;
    if (g < 0) return 0;
    if (g > longint'(GAIN_MAX)) return longint'(GAIN_MAX);
    return g;
  endfunction

  function automatic void reset_model();
    for (int i = 0; i < 4; i++) begin
      lowpass_state[i] = 0;
      split_state[i]   = 0;
    end
    for (int i = 0; i < 3; i++) past_samples[i] = 0;
    knob_low  = KNOB_RST;
    knob_mid  = KNOB_RST;
    knob_high = KNOB_RST;
    coef_low  = LOW_COEF_RST;
    coef_high = HIGH_COEF_RST;
  endfunction

  function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_LOW_KNOB:  knob_low  = data[KNOB_W-1:0];
      REG_MID_KNOB:  knob_mid  = data[KNOB_W-1:0];
      REG_HIGH_KNOB: knob_high = data[KNOB_W-1:0];
      REG_LOW_COEF:  coef_low  = data[COEF_W-1:0];
      REG_HIGH_COEF: coef_high = data[COEF_W-1:0];
      default: ;
    endcase
  endfunction

  // Advance the model by one item and return the equalised sample
  function automatic logic signed [SW-1:0] predict_sample(eq_item_t it);
    longint x, delayed, src, c_low, c_high;
    longint gl, gm, gh, low_b, mid_b, high_b, coarse, fine, total;
    gl = knob_plus_cv(knob_low,  it.low_cv);
    gm = knob_plus_cv(knob_mid,  it.mid_cv);
    gh = knob_plus_cv(knob_high, it.high_cv);
    x       = longint'(it.sample) <<< (PW - SW);
    delayed = past_samples[2] <<< (PW - SW);
    c_low   = (coef_low  > COEF_MAX) ? longint'(COEF_MAX) : longint'(coef_low);
    c_high  = (coef_high > COEF_MAX) ? longint'(COEF_MAX) : longint'(coef_high);
    for (int i = 0; i < 4; i++) begin
      src = (i == 0) ? x : lowpass_state[i - 1];
      lowpass_state[i] = clip(lowpass_state[i] +
                              scale_by_coef(c_low, src - lowpass_state[i]), PW);
    end
    for (int i = 0; i < 4; i++) begin
      src = (i == 0) ? x : split_state[i - 1];
      split_state[i] = clip(split_state[i] +
                            scale_by_coef(c_high, src - split_state[i]), PW);
    end
    low_b  = lowpass_state[3];
    high_b = delayed - split_state[3];
    mid_b  = delayed - (high_b + low_b);
    coarse = low_b * (gl >>> GAIN_SPLIT) + mid_b * (gm >>> GAIN_SPLIT) +
             high_b * (gh >>> GAIN_SPLIT);
    fine   = low_b * (gl & 255) + mid_b * (gm & 255) + high_b * (gh & 255);
    total  = coarse + (fine >>> GAIN_SPLIT);
    past_samples[2] = past_samples[1];
    past_samples[1] = past_samples[0];
    past_samples[0] = longint'(it.sample);
    return SW'(clip(total >>> OUT_SHIFT, SW));
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic eq_item_t make_item(logic signed [SW-1:0] s,
                                         logic signed [SW-1:0] l,
                                         logic signed [SW-1:0] m,
                                         logic signed [SW-1:0] h);
    eq_item_t it;
    it.sample  = s;
    it.low_cv  = l;
    it.mid_cv  = m;
    it.high_cv = h;
    return it;
  endfunction

  // Mostly mid-range voltages so the gains land between the clamps
  function automatic logic signed [SW-1:0] random_cv();
    if ($urandom_range(0, 3) == 0) return SW'($urandom);
    return SW'(int'($urandom_range(0, 2 * CV_SPAN)) - CV_SPAN);
  endfunction

  // A random walk gives the filters something band-limited to chew on;
  // a quarter of the samples are full-scale noise
  function automatic eq_item_t random_item();
    eq_item_t it;
    if ($urandom_range(0, 3) == 0) begin
      it.sample = SW'($urandom);
    end else begin
      walk_level = walk_level + SW'(int'($urandom_range(0, 2 * WALK_STEP)) - WALK_STEP);
      it.sample  = walk_level;
    end
    it.low_cv  = random_cv();
    it.mid_cv  = random_cv();
    it.high_cv = random_cv();
    return it;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_knob();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return CFG_DATA_W'(GAIN_MAX);
      2:       return CFG_DATA_W'(KNOB_RST);
      3:       return CFG_DATA_W'($urandom);  // upper data bits are dropped by the register
      default: return CFG_DATA_W'($urandom_range(0, GAIN_MAX));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_coef();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return COEF_MAX;
      2:       return DATA_ALL_ONES;
      3:       return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(0, COEF_MAX));
    endcase
  endfunction

  // Sender gap: mostly none, sometimes valid is held low first
  function automatic int idle_gap();
    if (calm || $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(1, 15);
  endfunction

  // Offer one item, hold it until taken, then log its expected output
  task automatic send_item(eq_item_t it);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    sample_in <= it.sample;
    low_cv    <= it.low_cv;
    mid_cv    <= it.mid_cv;
    high_cv   <= it.high_cv;
    do @(posedge clk_i); while (!in_ready_o);
    expected_samples.push_back(predict_sample(it));
  endtask

  // Drop valid and hold off until every expected output has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
  endtask

  // One register write per cycle; the caller lowers the enable afterwards
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    apply_reg_write(idx, data);
  endtask

  task automatic set_registers(logic [CFG_DATA_W-1:0] lk, logic [CFG_DATA_W-1:0] mk,
                               logic [CFG_DATA_W-1:0] hk, logic [CFG_DATA_W-1:0] lc,
                               logic [CFG_DATA_W-1:0] hc);
    drain();
    write_reg(REG_LOW_KNOB,  lk);
    write_reg(REG_MID_KNOB,  mk);
    write_reg(REG_HIGH_KNOB, hk);
    write_reg(REG_LOW_COEF,  lc);
    write_reg(REG_HIGH_COEF, hc);
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset settings: silence, full-scale samples and the floor of cv / 80
  // around zero (-1, 79, -80 give -1, 0, -1)
  task automatic test_reset_settings();
    send_item(make_item('0, '0, '0, '0));
    send_item(make_item(S_MAX, '0, '0, '0));
    send_item(make_item(S_MIN, '0, '0, '0));
    send_item(make_item(S_MAX, S_MAX, S_MAX, S_MAX));
    send_item(make_item(S_MIN, S_MIN, S_MIN, S_MIN));
    send_item(make_item(SW'(1), -SW'(1), SW'(79), -SW'(80)));
  endtask

  // Upper gain clamp and zero gains; a knob above 2.0 is still clamped after the sum
  task automatic test_gain_clamp();
    set_registers(DATA_ALL_ONES, '0, CFG_DATA_W'(GAIN_MAX), LOW_COEF_RST, HIGH_COEF_RST);
    send_item(make_item(S_MAX, -SW'(1), S_MAX, S_MIN));
    send_item(make_item(S_MIN, S_MIN, SW'(80), -SW'(81)));
    set_registers('0, '0, '0, LOW_COEF_RST, HIGH_COEF_RST);
    send_item(make_item(S_MAX, S_MAX, S_MAX, S_MAX));
    send_item(make_item(S_MAX, '0, '0, '0));
  endtask

  // Frozen poles with zero coefficients, then coefficients at and above 2.0
  // with alternating full-scale input so the poles and the output saturate
  task automatic test_coef_extremes();
    set_registers(CFG_DATA_W'(GAIN_MAX), CFG_DATA_W'(GAIN_MAX), CFG_DATA_W'(GAIN_MAX),
                  '0, '0);
    send_item(make_item(S_MAX, '0, '0, '0));
    send_item(make_item(S_MIN, '0, '0, '0));
    set_registers(CFG_DATA_W'(GAIN_MAX), CFG_DATA_W'(GAIN_MAX), CFG_DATA_W'(GAIN_MAX),
                  COEF_MAX, DATA_ALL_ONES);
    for (int i = 0; i < 6; i++)
      send_item(make_item((i % 2 == 0) ? S_MAX : S_MIN, S_MAX, S_MIN, S_MAX));
  endtask

  // Writes past the register map are dropped
  task automatic test_unknown_index();
    drain();
    for (int i = REG_UNUSED_FIRST; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    send_item(random_item());
    send_item(random_item());
  endtask

  // Phases of random traffic, each under fresh random settings; the last
  // phase runs with no idling on either side
  task automatic test_random_traffic();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      set_registers(random_knob(), random_knob(), random_knob(),
                    random_coef(), random_coef());
      if (phase == RANDOM_PHASES - 1) calm <= 1'b1;
      repeat (PHASE_ITEMS) send_item(random_item());
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    reset_model();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_settings();
    test_gain_clamp();
    test_coef_extremes();
    test_unknown_index();
    test_random_traffic();

    // Wait out the pipeline so a stray extra output is still caught
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // Receiver: alternate flow and stall bursts; always ready once calm
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready  <= 1'b0;
      burst_left <= 0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else if (burst_left != 0) begin
      burst_left <= burst_left - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      out_ready  <= 1'b0;
      burst_left <= $urandom_range(0, 14);
    end else begin
      out_ready  <= 1'b1;
      burst_left <= $urandom_range(0, 39);
    end
  end

  // Compare each output item with the oldest prediction
  always @(posedge clk_i) begin
    logic signed [SW-1:0] want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (expected_samples.size() == 0) begin
        $error("sample_out: no item expected, actual %0d", sample_out_o);
        error_count++;
      end else begin
        want = expected_samples.pop_front();
        if (sample_out_o !== want) begin
          $error("sample_out: expected %0d, actual %0d", want, sample_out_o);
          error_count++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule

// ----- files.f -----
hdl/tbe_pkg.sv
hdl/three_band_equalizer.sv
tb/tb.sv
